### design/cbrf_pkg.sv
package cbrf_pkg;

	// microprogram counter
	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// fixed entry points of the microprogram
	localparam upc_t UPC_LOOP = 5'd15;
	localparam upc_t UPC_FIN  = 5'd24;

	// micro-operations
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_LOAD_LO,
		UOP_LOAD_HI,
		UOP_MUL,
		UOP_ADD,
		UOP_CHECK,
		UOP_MID,
		UOP_DECIDE,
		UOP_TEST,
		UOP_FIN
	} uop_t;

	// coefficient added after a multiply
	typedef enum logic [1:0] {
		CSEL_SQUARE,
		CSEL_LINEAR,
		CSEL_CONST
	} csel_t;

	// one control word
	typedef struct packed {
		uop_t  op;
		csel_t csel;
		upc_t  target;
	} uword_t;

	// result status codes
	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_NO_SIGN   = 2'd1;
	localparam logic [1:0] ST_CAP       = 2'd2;
	localparam logic [1:0] ST_ZERO      = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_COEF_CUBIC  = 3'd0;
	localparam logic [2:0] REG_COEF_SQUARE = 3'd1;
	localparam logic [2:0] REG_COEF_LINEAR = 3'd2;
	localparam logic [2:0] REG_COEF_CONST  = 3'd3;
	localparam logic [2:0] REG_TOLERANCE   = 3'd4;

	// microprogram rom: two end evaluations, then the bisection loop
	function automatic uword_t ucode(upc_t pc);
		uword_t w;
		w = '{op: UOP_NOP, csel: CSEL_SQUARE, target: '0};
		unique case (pc)
			5'd0:  w.op = UOP_LOAD_LO;
			5'd1:  w.op = UOP_MUL;
			5'd2:  w = '{op: UOP_ADD, csel: CSEL_SQUARE, target: '0};
			5'd3:  w.op = UOP_MUL;
			5'd4:  w = '{op: UOP_ADD, csel: CSEL_LINEAR, target: '0};
			5'd5:  w.op = UOP_MUL;
			5'd6:  w = '{op: UOP_ADD, csel: CSEL_CONST, target: '0};
			5'd7:  w.op = UOP_LOAD_HI;
			5'd8:  w.op = UOP_MUL;
			5'd9:  w = '{op: UOP_ADD, csel: CSEL_SQUARE, target: '0};
			5'd10: w.op = UOP_MUL;
			5'd11: w = '{op: UOP_ADD, csel: CSEL_LINEAR, target: '0};
			5'd12: w.op = UOP_MUL;
			5'd13: w = '{op: UOP_ADD, csel: CSEL_CONST, target: '0};
			5'd14: w.op = UOP_CHECK;
			5'd15: w.op = UOP_MID;
			5'd16: w.op = UOP_MUL;
			5'd17: w = '{op: UOP_ADD, csel: CSEL_SQUARE, target: '0};
			5'd18: w.op = UOP_MUL;
			5'd19: w = '{op: UOP_ADD, csel: CSEL_LINEAR, target: '0};
			5'd20: w.op = UOP_MUL;
			5'd21: w = '{op: UOP_ADD, csel: CSEL_CONST, target: '0};
			5'd22: w.op = UOP_DECIDE;
			5'd23: w = '{op: UOP_TEST, csel: CSEL_SQUARE, target: UPC_LOOP};
			5'd24: w.op = UOP_FIN;
			default: w.op = UOP_NOP;
		endcase
		return w;
	endfunction

endpackage

### design/cubic_bisection_root_finder.sv
// an input transfer starts the two end evaluations; bisection steps then run until the
// tolerance test passes, the midpoint hits an exact zero or MAX_STEPS steps are done;
// with no sign change between the ends the result follows the end evaluations directly
// one item in work at a time; the next input transfer is taken once the result is registered
// each step runs a midpoint word, a Horner pass on the shared multiplier, then the decide
// and test words; the rom steps one word per cycle, but holds the fin word on a stall
// reset: coefficients and tolerance return to their defaults, sequencer idle, no result
module cubic_bisection_root_finder #(
	parameter int MAX_STEPS = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] lower_end,
	input  logic signed [31:0] upper_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] root,
	output logic [1:0]         status,
	output logic [6:0]         iterations
);
	import cbrf_pkg::*;

	// configuration registers
	logic signed [31:0] coef_cubic_q, coef_square_q, coef_linear_q, coef_const_q;
	logic [30:0]        tolerance_q;

	// sequencer state
	logic       busy_q;
	upc_t       upc_q;
	logic [6:0] steps_q;
	logic       out_valid_q;

	// datapath registers
	logic signed [31:0] lo_q, hi_q, x_q, acc_q, mid_q;
	logic signed [63:0] prod_q;
	logic               flo_neg_q, flo_zero_q;
	logic [1:0]         res_status_q;
	logic signed [31:0] root_q;
	logic [1:0]         status_q;
	logic [6:0]         iterations_q;

	uword_t             uw;
	logic               in_xfer, out_xfer, fin_go;
	logic signed [31:0] coef_sel;
	logic signed [63:0] shifted, sum;
	logic signed [31:0] sat_val;
	logic signed [32:0] mid_sum;
	logic signed [31:0] mid_new;
	logic signed [32:0] diff;
	logic [32:0]        diff_abs;
	logic               cap_hit, sign_change, close_enough;

	assign cfg_ready  = 1'b1;
	assign in_ready   = !busy_q;
	assign out_valid  = out_valid_q;
	assign root       = root_q;
	assign status     = status_q;
	assign iterations = iterations_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign uw       = ucode(upc_q);
	assign fin_go   = busy_q && (uw.op == UOP_FIN) && (!out_valid_q || out_ready);

	// coefficient select for the Horner add
	always_comb begin
		case (uw.csel)
			CSEL_SQUARE: coef_sel = coef_square_q;
			CSEL_LINEAR: coef_sel = coef_linear_q;
			CSEL_CONST:  coef_sel = coef_const_q;
			default:     coef_sel = coef_square_q;
		endcase
	end

	// floor shift of the product, add coefficient, clamp to 32 bits
	always_comb begin
		shifted = prod_q >>> FRAC_BITS;
		sum     = shifted + 64'(coef_sel);
		if (!sum[63] && (sum[62:31] != '0))
			sat_val = 32'sh7fff_ffff;
		else if (sum[63] && (sum[62:31] != '1))
			sat_val = -32'sh8000_0000;
		else
			sat_val = sum[31:0];
	end

	// midpoint of the current ends and its distance to the last midpoint
	always_comb begin
		mid_sum      = {lo_q[31], lo_q} + {hi_q[31], hi_q};
		mid_new      = mid_sum[32:1];
		diff         = {mid_new[31], mid_new} - {mid_q[31], mid_q};
		diff_abs     = diff[32] ? 33'(-diff) : 33'(diff);
		close_enough = diff_abs <= {2'b00, tolerance_q};
		cap_hit      = steps_q >= 7'(MAX_STEPS);
		sign_change  = !flo_zero_q && (acc_q != '0) && (flo_neg_q != acc_q[31]);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_cubic_q  <= '0;
			coef_square_q <= '0;
			coef_linear_q <= 32'sd65536;
			coef_const_q  <= '0;
			tolerance_q   <= 31'd66;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_CUBIC:  coef_cubic_q  <= cfg_data;
				REG_COEF_SQUARE: coef_square_q <= cfg_data;
				REG_COEF_LINEAR: coef_linear_q <= cfg_data;
				REG_COEF_CONST:  coef_const_q  <= cfg_data;
				REG_TOLERANCE:   tolerance_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// sequencer: program counter, step count, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			upc_q       <= '0;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;

			if (in_xfer) begin
				busy_q  <= 1'b1;
				upc_q   <= '0;
				steps_q <= '0;
			end else if (busy_q) begin
				unique case (uw.op)
					UOP_CHECK: begin
						upc_q <= sign_change ? upc_q + 1'b1 : UPC_FIN;
					end
					UOP_MID: begin
						if (cap_hit) begin
							upc_q <= UPC_FIN;
						end else begin
							upc_q   <= upc_q + 1'b1;
							steps_q <= steps_q + 1'b1;
						end
					end
					UOP_DECIDE: begin
						upc_q <= (acc_q == '0) ? UPC_FIN : upc_q + 1'b1;
					end
					UOP_TEST: begin
						upc_q <= close_enough ? UPC_FIN : uw.target;
					end
					UOP_FIN: begin
						if (fin_go) begin
							busy_q <= 1'b0;
							upc_q  <= '0;
						end
					end
					default: upc_q <= upc_q + 1'b1;
				endcase
			end
		end
	end

	// datapath driven by the control word
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lo_q  <= lower_end;
			hi_q  <= upper_end;
			mid_q <= '0;
		end else if (busy_q) begin
			unique case (uw.op)
				UOP_LOAD_LO: begin
					x_q   <= lo_q;
					acc_q <= coef_cubic_q;
				end
				UOP_LOAD_HI: begin
					flo_neg_q  <= acc_q[31];
					flo_zero_q <= (acc_q == '0);
					x_q        <= hi_q;
					acc_q      <= coef_cubic_q;
				end
				UOP_MUL: prod_q <= 64'(acc_q) * 64'(x_q);
				UOP_ADD: acc_q <= sat_val;
				UOP_CHECK: begin
					if (!sign_change) begin
						mid_q        <= '0;
						res_status_q <= ST_NO_SIGN;
					end
				end
				UOP_MID: begin
					if (cap_hit) begin
						res_status_q <= ST_CAP;
					end else begin
						mid_q <= mid_new;
						x_q   <= mid_new;
						acc_q <= coef_cubic_q;
					end
				end
				UOP_DECIDE: begin
					if (acc_q == '0) begin
						res_status_q <= ST_ZERO;
					end else if (flo_neg_q != acc_q[31]) begin
						hi_q <= mid_q;
					end else begin
						lo_q      <= mid_q;
						flo_neg_q <= acc_q[31];
					end
				end
				UOP_TEST: begin
					if (close_enough)
						res_status_q <= ST_CONVERGED;
				end
				UOP_FIN: begin
					if (fin_go) begin
						root_q       <= mid_q;
						status_q     <= res_status_q;
						iterations_q <= steps_q;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// step count never passes the cap
	a_steps_cap: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= 7'(MAX_STEPS))
		else $error("bisection step count above cap");

	// no sign change gives an empty result
	a_no_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_NO_SIGN) |-> (iterations_q == '0 && root_q == '0))
		else $error("no-sign-change result carries data");

	// a capped result used every step
	a_cap_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_CAP) |-> (iterations_q == 7'(MAX_STEPS)))
		else $error("cap status without full step count");

	// an input transfer restarts the microprogram
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (busy_q && upc_q == '0 && steps_q == '0))
		else $error("sequencer not started after input transfer");
`endif

endmodule

### tb/cubic_bisection_root_finder_tb.sv
`timescale 1ns / 1ps

module cubic_bisection_root_finder_tb;

	import cbrf_pkg::*;

	localparam int MAX_STEPS = 64;
	localparam int FRAC_BITS = 16;
	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1650;
	localparam int NUM_PHASES = 10;
	localparam int IDLE_GAP = 4;
	localparam int DRAIN_CYCLES = 1000;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int MAX_REPORTS = 40;

	localparam logic signed [31:0] ONE = 32'sd65536;
	localparam logic signed [31:0] INT_MIN32 = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX32 = 32'sh7fff_ffff;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	// highest register index, past the last real register
	localparam logic [2:0] REG_UNUSED_TOP = '1;

	typedef struct packed {
		logic signed [31:0] root;
		logic [1:0]         status;
		logic [6:0]         iterations;
	} root_result_t;

	typedef struct {
		bit                 is_cfg;
		logic [2:0]         idx;
		logic [31:0]        data;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		bit                 known;
		root_result_t       res;
	} dir_row_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_SPARSE,
		RX_PERIODIC,
		RX_COIN
	} rx_mode_t;

	typedef enum logic [1:0] {
		CS_GENTLE,
		CS_WIDE,
		CS_EXTREME
	} coef_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] lower_end = '0;
	logic signed [31:0] upper_end = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] root;
	logic [1:0] status;
	logic [6:0] iterations;

	// shadow of the register file, starts at the reset values
	logic signed [31:0] cur_cubic = '0;
	logic signed [31:0] cur_square = '0;
	logic signed [31:0] cur_linear = ONE;
	logic signed [31:0] cur_const = '0;
	logic [30:0] cur_tol = 31'd66;

	root_result_t expected_roots[$];
	dir_row_t directed_rows[$];
	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	rx_mode_t rx_mode = RX_ALWAYS;
	int rx_tick = 0;

	cubic_bisection_root_finder #(
		.MAX_STEPS(MAX_STEPS),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.lower_end(lower_end),
		.upper_end(upper_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.root(root),
		.status(status),
		.iterations(iterations)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// fixed-point arithmetic of the root finder

	function automatic longint clamp32(input longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	// exact product, then floor shift back to the fixed-point scale
	function automatic longint fix_mul(input longint a, input longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	// horner evaluation with a clamp after every stage
	function automatic longint cubic_at(input longint x);
		longint acc;
		acc = longint'(cur_cubic);
		acc = clamp32(fix_mul(acc, x) + longint'(cur_square));
		acc = clamp32(fix_mul(acc, x) + longint'(cur_linear));
		acc = clamp32(fix_mul(acc, x) + longint'(cur_const));
		return acc;
	endfunction

	function automatic bit opposite(input longint a, input longint b);
		return (a > 0 && b < 0) || (a < 0 && b > 0);
	endfunction

	function automatic root_result_t find_root(input logic signed [31:0] lower,
			input logic signed [31:0] upper);
		longint lo, hi, flo, fhi, mid, fm, nxt, span;
		int steps;
		bit done;
		root_result_t r;
		lo = longint'(lower);
		hi = longint'(upper);
		flo = cubic_at(lo);
		fhi = cubic_at(hi);
		r.root = '0;
		r.status = ST_NO_SIGN;
		r.iterations = '0;
		if (!opposite(flo, fhi)) return r;
		mid = 0;
		steps = 0;
		done = 1'b0;
		r.status = ST_CAP;
		while (!done && steps < MAX_STEPS) begin
			mid = (lo + hi) >>> 1;
			steps++;
			fm = cubic_at(mid);
			if (fm == 0) begin
				r.status = ST_ZERO;
				done = 1'b1;
			end else begin
				// keep the half that still brackets the sign change
				if (opposite(flo, fm)) begin
					hi = mid;
				end else begin
					lo = mid;
					flo = fm;
				end
				nxt = (lo + hi) >>> 1;
				span = nxt - mid;
				if (span < 0) span = -span;
				if (span <= longint'(cur_tol)) begin
					r.status = ST_CONVERGED;
					done = 1'b1;
				end
			end
		end
		r.root = mid[31:0];
		r.iterations = steps[6:0];
		return r;
	endfunction

	// directed rows

	function automatic void dir_cfg(input logic [2:0] idx, input logic [31:0] data);
		dir_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		row.lo = '0;
		row.hi = '0;
		row.known = 1'b0;
		row.res = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void dir_item(input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.idx = '0;
		row.data = '0;
		row.lo = lo;
		row.hi = hi;
		row.known = 1'b0;
		row.res = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void dir_known(input logic signed [31:0] lo,
			input logic signed [31:0] hi, input logic signed [31:0] r,
			input logic [1:0] st, input logic [6:0] it);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.idx = '0;
		row.data = '0;
		row.lo = lo;
		row.hi = hi;
		row.known = 1'b1;
		row.res.root = r;
		row.res.status = st;
		row.res.iterations = it;
		directed_rows.push_back(row);
	endfunction

	// bus tasks

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_COEF_CUBIC:  cur_cubic = data;
			REG_COEF_SQUARE: cur_square = data;
			REG_COEF_LINEAR: cur_linear = data;
			REG_COEF_CONST:  cur_const = data;
			REG_TOLERANCE:   cur_tol = data[30:0];
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic send_interval(input logic signed [31:0] lo,
			input logic signed [31:0] hi, input bit known, input root_result_t res);
		@(negedge clk);
		in_valid <= 1'b1;
		lower_end <= lo;
		upper_end <= hi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_roots.push_back(known ? res : find_root(lo, hi));
	endtask

	// bursts of back-to-back intervals, then, when gaps are on, a gap, short or long
	task automatic pause_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if (gaps_on) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400)
					: $urandom_range(1, 24);
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// drop valid and let every pending root come back
	task automatic wait_idle();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_roots.size() != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic program_phase(input int phase);
		coef_style_t style;
		logic [31:0] val;
		if (phase == 0) style = CS_GENTLE;
		else if (phase == 1) style = CS_EXTREME;
		else if (phase == 2) style = CS_WIDE;
		else begin
			case ($urandom_range(0, 3))
				0, 1: style = CS_GENTLE;
				2: style = CS_WIDE;
				default: style = CS_EXTREME;
			endcase
		end
		// coefficient registers sit at consecutive indexes
		for (int j = 0; j < 4; j++) begin
			case (style)
				CS_GENTLE: val = 32'($urandom_range(0, 16 * 65536)) - 32'(8 * 65536);
				CS_WIDE: val = $urandom;
				default: begin
					case ($urandom_range(0, 4))
						0: val = INT_MIN32;
						1: val = INT_MAX32;
						2: val = '0;
						3: val = ONE;
						default: val = -ONE;
					endcase
				end
			endcase
			write_reg(REG_COEF_CUBIC + 3'(j), val);
		end
		if (phase == 0) begin
			val = '0;
		end else if (phase == 1) begin
			val = '1;
		end else begin
			case ($urandom_range(0, 3))
				0: val = $urandom_range(0, 15);
				1: val = $urandom_range(0, 2047);
				2: val = $urandom_range(0, 65536);
				default: val = $urandom;
			endcase
			val[31] = 1'($urandom_range(0, 1));
		end
		write_reg(REG_TOLERANCE, val);
		// writes past the last register must leave everything alone
		if ($urandom_range(0, 1) == 1)
			write_reg(3'($urandom_range(int'(REG_TOLERANCE) + 1, int'(REG_UNUSED_TOP))),
				$urandom);
	endtask

	// mostly intervals that bracket a sign change, some raw noise
	task automatic pick_interval(output logic signed [31:0] lo,
			output logic signed [31:0] hi);
		bit bracketed;
		lo = $urandom;
		hi = $urandom;
		if ($urandom_range(0, 4) != 0) begin
			bracketed = 1'b0;
			for (int t = 0; t < 16 && !bracketed; t++) begin
				lo = $signed($urandom) >>> $urandom_range(0, 31);
				hi = $signed($urandom) >>> $urandom_range(0, 31);
				bracketed = opposite(cubic_at(longint'(lo)), cubic_at(longint'(hi)));
			end
		end
	endtask

	// receiver stall pattern; the mode is redrawn at random while the run goes on
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 256 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_ALWAYS:   out_ready <= 1'b1;
			RX_SPARSE:   out_ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_ready <= (rx_tick % 16 >= 7);
			default:     out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	task automatic flag_field(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (error_count < MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		error_count++;
	endtask

	// compare each result transfer against the oldest expectation
	always @(posedge clk) begin : check_results
		root_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_roots.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("%0t: extra result, expected none, actual %0d/%0d/%0d",
						$time, root, status, iterations);
				error_count++;
			end else begin
				want = expected_roots.pop_front();
				if (root !== want.root) flag_field("root", 64'(want.root), 64'(root));
				if (status !== want.status)
					flag_field("status", 64'(want.status), 64'(status));
				if (iterations !== want.iterations)
					flag_field("iterations", 64'(want.iterations), 64'(iterations));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		logic signed [31:0] lo, hi;
		dir_row_t row;

		// reset config: f(x) = x, tolerance 66
		dir_known(32'sd0, 32'sd0, 32'sd0, ST_NO_SIGN, 7'd0);
		dir_known(32'sd0, 100 * ONE, 32'sd0, ST_NO_SIGN, 7'd0);
		dir_known(5 * ONE, 10 * ONE, 32'sd0, ST_NO_SIGN, 7'd0);
		dir_known(-ONE, ONE, 32'sd0, ST_ZERO, 7'd1);
		dir_item(INT_MIN32, INT_MAX32);
		dir_item(INT_MAX32, INT_MIN32);
		dir_item(-3 * ONE, 7 * ONE);
		// top data bit is dropped, tolerance goes to its maximum
		dir_cfg(REG_TOLERANCE, 32'hffff_ffff);
		dir_known(-32'sd100, 32'sd50, -32'sd25, ST_CONVERGED, 7'd1);
		dir_cfg(REG_TOLERANCE, 32'h0000_0000);
		dir_item(-32'sd1000, 32'sd12345);
		dir_item(INT_MIN32, INT_MAX32);
		dir_cfg(REG_UNUSED_TOP, 32'hffff_ffff);
		dir_item(5 * ONE, -ONE);
		// extreme coefficients, horner stages saturate
		dir_cfg(REG_COEF_CUBIC, INT_MAX32);
		dir_cfg(REG_COEF_SQUARE, INT_MIN32);
		dir_cfg(REG_COEF_LINEAR, INT_MIN32);
		dir_cfg(REG_COEF_CONST, INT_MAX32);
		dir_item(INT_MIN32, INT_MAX32);
		dir_item(INT_MAX32, 32'sd0);
		dir_item(-ONE, ONE);
		// x^2 - 2, roots at plus and minus sqrt 2
		dir_cfg(REG_COEF_CUBIC, 32'h0000_0000);
		dir_cfg(REG_COEF_SQUARE, ONE);
		dir_cfg(REG_COEF_LINEAR, 32'h0000_0000);
		dir_cfg(REG_COEF_CONST, -2 * ONE);
		dir_cfg(REG_TOLERANCE, 32'h0000_0001);
		dir_item(32'sd0, 2 * ONE);
		dir_item(-2 * ONE, 32'sd0);
		dir_known(-2 * ONE, 2 * ONE, 32'sd0, ST_NO_SIGN, 7'd0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed part
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				wait_idle();
				write_reg(row.idx, row.data);
			end else begin
				send_interval(row.lo, row.hi, row.known, row.res);
				pause_sender();
			end
		end

		// random part, one register setting per phase
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_idle();
			program_phase(phase);
			gaps_on = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
				pick_interval(lo, hi);
				send_interval(lo, hi, 1'b0, '0);
				pause_sender();
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
